[hw/rtl/scrolling_text_cell_buffer_assert.svh]
// assertion macros for the cell buffer checks
`ifndef SCROLLING_TEXT_CELL_BUFFER_ASSERT_SVH
`define SCROLLING_TEXT_CELL_BUFFER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define STCB_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stcb check failed");

// next-cycle implication, sampled on clk, off during reset
`define STCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stcb check failed");

`endif

[hw/rtl/stcb_pkg.sv]
package stcb_pkg;

  // default geometry
  localparam int COLUMNS_DEF = 64;
  localparam int ROWS_DEF    = 32;

  // fixed field widths of the ports
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 16;
  localparam int IN_ROW_W  = 5;
  localparam int IN_COL_W  = 6;
  localparam int OUT_ROW_W = 6;
  localparam int OUT_COL_W = 7;

  localparam logic [CHAR_W-1:0]  SPACE_CHAR = 8'h20;
  localparam logic [COLOR_W-1:0] FG_RESET   = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_RESET   = 16'h0000;

  // configuration register indexes
  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_CLEAN = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_FILL,
    ST_WRCHR,
    ST_RD,
    ST_DONE
  } state_t;

  // one character cell as stored
  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } cell_t;

endpackage

[hw/rtl/stcb_cell_ram.sv]
module stcb_cell_ram
  import stcb_pkg::*;
#(
  parameter int DEPTH = ROWS_DEF * COLUMNS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  cell_t                    wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output cell_t                    rd_data
);

  cell_t mem [DEPTH];
  cell_t rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/scrolling_text_cell_buffer.sv]
// Scrolling text cell buffer: ROWS x COLUMNS character cells kept as a ring of rows.
// Input channel (in_valid/in_ready) takes one command word: write character,
// read cell, clear all, or reset the dirty rectangle. Every command returns one
// result word on the output channel (out_valid/out_ready) with the read cell (zero
// unless it was an in-range read), the rows in use and the dirty rectangle after
// the command. Colors are set through cfg_we/cfg_index/cfg_data while the block is
// idle; that binds the user, and the block itself does not enforce it.
// A plain character write or an in-range read passes the accept cycle and one cell
// RAM access (one write, or one read with registered data). A write that wraps to
// a new row adds the wrap state, plus a pass that blanks the reused row when the
// screen scrolls. Clear all blanks every cell, one per cycle. A dirty reset or an
// out-of-range read goes straight to the finish state.
// Reset runs the same blanking pass over all ROWS*COLUMNS cells (2048 by default),
// with in_ready low; configuration writes are taken meanwhile.
// The result sits in an output register: a new command is accepted while it waits,
// and that command holds its own result until the output register is taken.
module scrolling_text_cell_buffer
  import stcb_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [IN_ROW_W-1:0]  in_cell_row,
  input  logic [IN_COL_W-1:0]  in_cell_column,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAR_W-1:0]    out_cell_char,
  output logic [COLOR_W-1:0]   out_cell_fg,
  output logic [COLOR_W-1:0]   out_cell_bg,
  output logic [OUT_ROW_W-1:0] out_rows_used,
  output logic [OUT_ROW_W-1:0] out_dirty_row_from,
  output logic [OUT_ROW_W-1:0] out_dirty_row_to,
  output logic [OUT_COL_W-1:0] out_dirty_col_from,
  output logic [OUT_COL_W-1:0] out_dirty_col_to
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ROW1_W = $clog2(ROWS + 1);
  localparam int COL1_W = $clog2(COLUMNS + 1);
  localparam int ADDR_W = $clog2(CELLS);

  typedef struct packed {
    logic [ROW1_W-1:0] row_from;
    logic [ROW1_W-1:0] row_to;
    logic [COL1_W-1:0] col_from;
    logic [COL1_W-1:0] col_to;
  } dirty_t;

  localparam dirty_t DIRTY_WHOLE = '{
    row_from: '0,
    row_to:   ROW1_W'(ROWS),
    col_from: '0,
    col_to:   COL1_W'(COLUMNS)
  };

  // ring row helpers
  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
    return (r == ROW_W'(ROWS - 1)) ? '0 : r + 1'b1;
  endfunction

  function automatic logic [ROW_W-1:0] row_logical(input logic [ROW_W-1:0] w,
                                                   input logic [ROW_W-1:0] t);
    logic [ROW_W:0] s;
    s = {1'b0, w} + (ROW_W+1)'(ROWS) - {1'b0, t};
    if (s >= (ROW_W+1)'(ROWS)) begin
      s = s - (ROW_W+1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  // requested row folded into the ring, a small constant table
  function automatic logic [ROW_W-1:0] row_fold(input logic [IN_ROW_W-1:0] r);
    logic [ROW_W-1:0] f;
    f = '0;
    for (int i = 0; i < (1 << IN_ROW_W); i++) begin
      if (r == IN_ROW_W'(i)) begin
        f = ROW_W'(i % ROWS);
      end
    end
    return f;
  endfunction

  // grow the dirty rectangle by the span cur..col_end on logical row r
  function automatic dirty_t widen(input dirty_t d, input logic [ROW_W-1:0] r,
                                   input logic [COL1_W-1:0] cur,
                                   input logic [COL1_W-1:0] col_end);
    dirty_t n;
    logic [ROW1_W-1:0] r0;
    logic [ROW1_W-1:0] r1;
    r0 = ROW1_W'(r);
    r1 = r0 + 1'b1;
    n  = d;
    if ((d.row_from == d.row_to) && (d.col_from == d.col_to)) begin
      n.row_from = r0;
      n.row_to   = r1;
      n.col_from = cur;
      n.col_to   = col_end;
    end else begin
      if (r0 < d.row_from) n.row_from = r0;
      if (r1 > d.row_to) n.row_to = r1;
      if (cur < d.col_from) n.col_from = cur;
      if (col_end > d.col_to) n.col_to = col_end;
    end
    return n;
  endfunction

  state_t              state_r, state_nxt;
  state_t              fill_ret_r, fill_ret_nxt;
  logic [ADDR_W-1:0]   fill_addr_r, fill_addr_nxt;
  logic [ADDR_W-1:0]   fill_end_r, fill_end_nxt;
  logic [ROW_W-1:0]    wr_row_r, wr_row_nxt;
  logic [ROW_W-1:0]    top_row_r, top_row_nxt;
  logic [COL1_W-1:0]   cursor_r, cursor_nxt;
  dirty_t              dirty_r, dirty_nxt;
  logic                op_rd_r, op_rd_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]  fg_color_r;
  logic [COLOR_W-1:0]  bg_color_r;
  logic [CHAR_W-1:0]   code_r;

  cell_t               out_cell_r;
  logic [OUT_ROW_W-1:0] out_rows_used_r;
  dirty_t              out_dirty_r;

  logic                accept;
  logic                slot_free;
  logic                load_out;
  func_t               func;
  logic                col_ok;
  logic [ROW_W:0]      rd_row_sum;
  logic [ROW_W-1:0]    rd_row;
  logic [ROW_W-1:0]    lwr;
  logic [ROW_W:0]      used_cnt;

  logic                mem_wr_en;
  logic [ADDR_W-1:0]   mem_wr_addr;
  cell_t               mem_wr_data;
  logic                mem_rd_en;
  logic [ADDR_W-1:0]   mem_rd_addr;
  cell_t               mem_rd_data;

  stcb_cell_ram #(
    .DEPTH(CELLS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign func      = func_t'(in_func);
  assign col_ok    = 32'(in_cell_column) < 32'(COLUMNS);
  assign lwr       = row_logical(wr_row_r, top_row_r);

  // physical row of a read
  always_comb begin
    rd_row_sum = {1'b0, row_fold(in_cell_row)} + {1'b0, top_row_r};
    if (rd_row_sum >= (ROW_W+1)'(ROWS)) begin
      rd_row_sum = rd_row_sum - (ROW_W+1)'(ROWS);
    end
    rd_row = rd_row_sum[ROW_W-1:0];
  end

  // sequencer: next state, ring pointers, dirty rectangle and RAM access
  always_comb begin
    state_nxt     = state_r;
    fill_ret_nxt  = fill_ret_r;
    fill_addr_nxt = fill_addr_r;
    fill_end_nxt  = fill_end_r;
    wr_row_nxt    = wr_row_r;
    top_row_nxt   = top_row_r;
    cursor_nxt    = cursor_r;
    dirty_nxt     = dirty_r;
    op_rd_nxt     = op_rd_r;
    load_out      = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = ADDR_W'(wr_row_r * COLUMNS) + ADDR_W'(cursor_r);
    mem_wr_data   = '{ch: code_r, fg: fg_color_r, bg: bg_color_r};
    mem_rd_en     = 1'b0;
    mem_rd_addr   = ADDR_W'(rd_row * COLUMNS) + ADDR_W'(in_cell_column);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_rd_nxt = 1'b0;
          case (func)
            FUNC_WRITE: begin
              if (cursor_r >= COL1_W'(COLUMNS)) begin
                cursor_nxt = '0;
                wr_row_nxt = row_inc(wr_row_r);
                state_nxt  = ST_WRAP;
              end else begin
                state_nxt  = ST_WRCHR;
              end
            end
            FUNC_READ: begin
              if (col_ok) begin
                op_rd_nxt = 1'b1;
                mem_rd_en = 1'b1;
                state_nxt = ST_RD;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            FUNC_CLEAR: begin
              wr_row_nxt    = '0;
              top_row_nxt   = '0;
              cursor_nxt    = '0;
              dirty_nxt     = DIRTY_WHOLE;
              fill_addr_nxt = '0;
              fill_end_nxt  = ADDR_W'(CELLS - 1);
              fill_ret_nxt  = ST_DONE;
              state_nxt     = ST_FILL;
            end
            FUNC_CLEAN: begin
              dirty_nxt = '{row_from: ROW1_W'(lwr), row_to: ROW1_W'(lwr),
                            col_from: cursor_r, col_to: cursor_r};
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      // new row reached: mark its start, scroll when it is the top row
      ST_WRAP: begin
        dirty_nxt = widen(dirty_r, lwr, cursor_r, cursor_r);
        if (wr_row_r == top_row_r) begin
          top_row_nxt   = row_inc(top_row_r);
          dirty_nxt     = DIRTY_WHOLE;
          fill_addr_nxt = ADDR_W'(wr_row_r * COLUMNS);
          fill_end_nxt  = ADDR_W'(wr_row_r * COLUMNS) + ADDR_W'(COLUMNS - 1);
          fill_ret_nxt  = ST_WRCHR;
          state_nxt     = ST_FILL;
        end else begin
          state_nxt     = ST_WRCHR;
        end
      end
      // blank cells one per cycle in the current colors
      ST_FILL: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = fill_addr_r;
        mem_wr_data = '{ch: SPACE_CHAR, fg: fg_color_r, bg: bg_color_r};
        if (fill_addr_r == fill_end_r) begin
          state_nxt = fill_ret_r;
        end else begin
          fill_addr_nxt = fill_addr_r + 1'b1;
        end
      end
      ST_WRCHR: begin
        mem_wr_en  = 1'b1;
        dirty_nxt  = widen(dirty_r, lwr, cursor_r, cursor_r + 1'b1);
        cursor_nxt = cursor_r + 1'b1;
        load_out   = slot_free;
        state_nxt  = slot_free ? ST_IDLE : ST_DONE;
      end
      ST_RD, ST_DONE: begin
        load_out  = slot_free;
        state_nxt = slot_free ? ST_IDLE : ST_DONE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_ret_r  <= ST_IDLE;
      fill_addr_r <= '0;
      fill_end_r  <= ADDR_W'(CELLS - 1);
      wr_row_r    <= '0;
      top_row_r   <= '0;
      cursor_r    <= '0;
      dirty_r     <= DIRTY_WHOLE;
      op_rd_r     <= 1'b0;
      out_valid_r <= 1'b0;
      fg_color_r  <= FG_RESET;
      bg_color_r  <= BG_RESET;
    end else begin
      state_r     <= state_nxt;
      fill_ret_r  <= fill_ret_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_end_r  <= fill_end_nxt;
      wr_row_r    <= wr_row_nxt;
      top_row_r   <= top_row_nxt;
      cursor_r    <= cursor_nxt;
      dirty_r     <= dirty_nxt;
      op_rd_r     <= op_rd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FG:  fg_color_r <= cfg_data;
          CFG_BG:  bg_color_r <= cfg_data;
          default: fg_color_r <= fg_color_r;
        endcase
      end
    end
  end

  // rows in use after the command
  assign used_cnt = (ROW_W+1)'(row_logical(wr_row_nxt, top_row_nxt)) + 1'b1;

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      code_r <= in_char_code;
    end
    if (load_out) begin
      out_cell_r      <= op_rd_r ? mem_rd_data : '0;
      out_rows_used_r <= OUT_ROW_W'(used_cnt);
      out_dirty_r     <= dirty_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cell_char      = out_cell_r.ch;
  assign out_cell_fg        = out_cell_r.fg;
  assign out_cell_bg        = out_cell_r.bg;
  assign out_rows_used      = out_rows_used_r;
  assign out_dirty_row_from = OUT_ROW_W'(out_dirty_r.row_from);
  assign out_dirty_row_to   = OUT_ROW_W'(out_dirty_r.row_to);
  assign out_dirty_col_from = OUT_COL_W'(out_dirty_r.col_from);
  assign out_dirty_col_to   = OUT_COL_W'(out_dirty_r.col_to);

  // checks
  `include "scrolling_text_cell_buffer_assert.svh"

  `STCB_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != ST_IDLE)
  `STCB_ASSERT_IMPLIES(a_fill_in_bounds, state_r == ST_FILL, fill_addr_r <= fill_end_r)
  `STCB_ASSERT_IMPLIES(a_write_inside_line, state_r == ST_WRCHR,
                       cursor_r < COL1_W'(COLUMNS))
  `STCB_ASSERT_IMPLIES(a_result_from_finish, $rose(out_valid_r),
                       $past(state_r) == ST_WRCHR || $past(state_r) == ST_RD ||
                       $past(state_r) == ST_DONE)

endmodule

[dv/tb_scrolling_text_cell_buffer.sv]
`timescale 1ns / 1ps

module tb_scrolling_text_cell_buffer;
  import stcb_pkg::*;

  localparam int COLS        = COLUMNS_DEF;
  localparam int ROWS        = ROWS_DEF;
  localparam int SCREEN      = COLS * ROWS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 4 * COLS;

  // one result word as seen on the output channel
  typedef struct packed {
    logic [CHAR_W-1:0]    ch;
    logic [COLOR_W-1:0]   fg;
    logic [COLOR_W-1:0]   bg;
    logic [OUT_ROW_W-1:0] used;
    logic [OUT_ROW_W-1:0] row_from;
    logic [OUT_ROW_W-1:0] row_to;
    logic [OUT_COL_W-1:0] col_from;
    logic [OUT_COL_W-1:0] col_to;
  } screen_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [COLOR_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_func;
  logic [CHAR_W-1:0]    in_char_code;
  logic [IN_ROW_W-1:0]  in_cell_row;
  logic [IN_COL_W-1:0]  in_cell_column;
  logic                 out_valid;
  logic                 out_ready;
  logic [CHAR_W-1:0]    out_cell_char;
  logic [COLOR_W-1:0]   out_cell_fg;
  logic [COLOR_W-1:0]   out_cell_bg;
  logic [OUT_ROW_W-1:0] out_rows_used;
  logic [OUT_ROW_W-1:0] out_dirty_row_from;
  logic [OUT_ROW_W-1:0] out_dirty_row_to;
  logic [OUT_COL_W-1:0] out_dirty_col_from;
  logic [OUT_COL_W-1:0] out_dirty_col_to;

  // shadow copy of the screen, cursor and dirty rectangle
  logic [CHAR_W-1:0]  shadow_char [SCREEN];
  logic [COLOR_W-1:0] shadow_fg   [SCREEN];
  logic [COLOR_W-1:0] shadow_bg   [SCREEN];
  int unsigned        wr_row, top_row, cur_col;
  int unsigned        dr_from, dr_to, dc_from, dc_to;
  logic [COLOR_W-1:0] fg_reg, bg_reg;

  screen_result_t pending_results [$];
  int unsigned    fail_count = 0;
  int unsigned    cycle_count = 0;
  bit             no_idle = 1'b0;
  bit             long_hold = 1'b0;
  bit             offering = 1'b0;

  scrolling_text_cell_buffer DUT (.*);

  always #5 clk = ~clk;

  // screen model
  function automatic int unsigned logical_row();
    return (ROWS + wr_row - top_row) % ROWS;
  endfunction

  function automatic void grow_dirty(int unsigned col_end);
    int unsigned r;
    r = logical_row();
    // an empty rectangle is replaced, not merged
    if (dr_from == dr_to && dc_from == dc_to) begin
      dr_from = r;
      dr_to   = r + 1;
      dc_from = cur_col;
      dc_to   = col_end;
    end else begin
      if (r < dr_from) dr_from = r;
      if (r + 1 > dr_to) dr_to = r + 1;
      if (cur_col < dc_from) dc_from = cur_col;
      if (col_end > dc_to) dc_to = col_end;
    end
  endfunction

  function automatic void whole_dirty();
    dr_from = 0;
    dr_to   = ROWS;
    dc_from = 0;
    dc_to   = COLS;
  endfunction

  function automatic void blank_row(int unsigned r);
    for (int i = 0; i < COLS; i++) begin
      shadow_char[r * COLS + i] = SPACE_CHAR;
      shadow_fg[r * COLS + i]   = fg_reg;
      shadow_bg[r * COLS + i]   = bg_reg;
    end
  endfunction

  function automatic void blank_screen();
    for (int r = 0; r < ROWS; r++) blank_row(r);
    wr_row  = 0;
    top_row = 0;
    cur_col = 0;
    whole_dirty();
  endfunction

  // new line; scrolls when the write row meets the top row
  function automatic void advance_row();
    cur_col = 0;
    wr_row  = (wr_row + 1) % ROWS;
    grow_dirty(cur_col);
    if (wr_row == top_row) begin
      top_row = (top_row + 1) % ROWS;
      blank_row(wr_row);
      whole_dirty();
    end
  endfunction

  function automatic screen_result_t apply_command(func_t f, logic [CHAR_W-1:0] code,
                                                   logic [IN_ROW_W-1:0] row,
                                                   logic [IN_COL_W-1:0] col);
    screen_result_t res;
    int unsigned    k;
    res = '0;
    case (f)
      FUNC_WRITE: begin
        if (cur_col >= COLS) advance_row();
        k = wr_row * COLS + cur_col;
        shadow_char[k] = code;
        shadow_fg[k]   = fg_reg;
        shadow_bg[k]   = bg_reg;
        grow_dirty(cur_col + 1);
        cur_col++;
      end
      FUNC_READ: begin
        // logical row wraps around the ring
        k = ((row + top_row) % ROWS) * COLS + col;
        res.ch = shadow_char[k];
        res.fg = shadow_fg[k];
        res.bg = shadow_bg[k];
      end
      FUNC_CLEAR: begin
        blank_screen();
      end
      default: begin
        dr_from = logical_row();
        dr_to   = dr_from;
        dc_from = cur_col;
        dc_to   = cur_col;
      end
    endcase
    res.used     = OUT_ROW_W'(logical_row() + 1);
    res.row_from = OUT_ROW_W'(dr_from);
    res.row_to   = OUT_ROW_W'(dr_to);
    res.col_from = OUT_COL_W'(dc_from);
    res.col_to   = OUT_COL_W'(dc_to);
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    screen_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no command outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("cell_char", 32'(want.ch), 32'(out_cell_char));
        check_field("cell_fg", 32'(want.fg), 32'(out_cell_fg));
        check_field("cell_bg", 32'(want.bg), 32'(out_cell_bg));
        check_field("rows_used", 32'(want.used), 32'(out_rows_used));
        check_field("dirty_row_from", 32'(want.row_from), 32'(out_dirty_row_from));
        check_field("dirty_row_to", 32'(want.row_to), 32'(out_dirty_row_to));
        check_field("dirty_col_from", 32'(want.col_from), 32'(out_dirty_col_from));
        check_field("dirty_col_to", 32'(want.col_to), 32'(out_dirty_col_to));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold when asked
  initial begin : result_side
    int unsigned held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        long_hold = 1'b0;
      end
      out_ready <= no_idle || ($urandom_range(99) >= 6);
    end
  end

  // offer one command word and wait until it is taken
  task automatic send_cmd(func_t f, logic [CHAR_W-1:0] code, logic [IN_ROW_W-1:0] row,
                          logic [IN_COL_W-1:0] col);
    while (!no_idle && $urandom_range(99) < 6) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    offering       = 1'b1;
    in_func        <= f;
    in_char_code   <= code;
    in_cell_row    <= row;
    in_cell_column <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_command(f, code, row, col));
    @(negedge clk);
  endtask

  task automatic send_random(int unsigned w_pct, int unsigned r_pct, int unsigned d_pct);
    int unsigned p;
    func_t       f;
    p = $urandom_range(99);
    if (p < w_pct) f = FUNC_WRITE;
    else if (p < w_pct + r_pct) f = FUNC_READ;
    else if (p < w_pct + r_pct + d_pct) f = FUNC_CLEAN;
    else f = FUNC_CLEAR;
    send_cmd(f, CHAR_W'($urandom_range(255)), IN_ROW_W'($urandom_range(ROWS - 1)),
             IN_COL_W'($urandom_range(COLS - 1)));
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      @(negedge clk);
    end
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // write both color registers, block idle
  task automatic set_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FG;
    cfg_data  <= fg;
    @(posedge clk);
    fg_reg = fg;
    @(negedge clk);
    cfg_index <= CFG_BG;
    cfg_data  <= bg;
    @(posedge clk);
    bg_reg = bg;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // contents after reset, char extremes, clean rectangle, clear
  task automatic test_reset_state();
    send_cmd(FUNC_READ, 8'h00, 5'd0, 6'd0);
    send_cmd(FUNC_READ, 8'hFF, 5'd31, 6'd63);
    send_cmd(FUNC_CLEAN, 8'h00, 5'd0, 6'd0);
    send_cmd(FUNC_WRITE, 8'h41, 5'd31, 6'd63);
    send_cmd(FUNC_WRITE, 8'h00, 5'd0, 6'd0);
    send_cmd(FUNC_WRITE, 8'hFF, 5'd31, 6'd63);
    for (int c = 0; c < 3; c++) send_cmd(FUNC_READ, 8'h00, 5'd0, IN_COL_W'(c));
    send_cmd(FUNC_READ, 8'h00, 5'd1, 6'd0);
    send_cmd(FUNC_CLEAN, 8'hFF, 5'd31, 6'd63);
    send_cmd(FUNC_WRITE, 8'h42, 5'd0, 6'd0);
    send_cmd(FUNC_CLEAR, 8'h00, 5'd0, 6'd0);
    send_cmd(FUNC_READ, 8'h00, 5'd0, 6'd1);
  endtask

  // color registers at their extremes and one random setting
  task automatic test_color_registers();
    logic [COLOR_W-1:0] fgs [3];
    logic [COLOR_W-1:0] bgs [3];
    fgs = '{16'h0000, 16'hFFFF, COLOR_W'($urandom)};
    bgs = '{16'hFFFF, 16'h0000, COLOR_W'($urandom)};
    for (int i = 0; i < 3; i++) begin
      drain();
      set_colors(fgs[i], bgs[i]);
      send_cmd(FUNC_CLEAR, 8'h00, 5'd0, 6'd0);
      send_cmd(FUNC_WRITE, CHAR_W'($urandom_range(255)), 5'd0, 6'd0);
      send_cmd(FUNC_READ, 8'h00, 5'd0, 6'd0);
      send_cmd(FUNC_READ, 8'h00, IN_ROW_W'($urandom_range(ROWS - 1)),
               IN_COL_W'($urandom_range(COLS - 1)));
    end
  endtask

  // long text runs: line wraps and several scrolls
  task automatic test_text_stream();
    drain();
    set_colors(COLOR_W'($urandom), COLOR_W'($urandom));
    send_cmd(FUNC_CLEAR, 8'h00, 5'd0, 6'd0);
    for (int i = 0; i < 2300; i++) begin
      no_idle = (i >= 1000 && i < 1400);
      send_random(96, 3, 1);
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off while commands keep coming, then sender pauses
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 40; i++) send_random(70, 20, 10);
    drain();
    for (int i = 0; i < 20; i++) send_random(70, 20, 10);
  endtask

  // all functions, clears included, colors changed between phases
  task automatic test_mixed_random();
    for (int i = 0; i < 300; i++) begin
      if (i % 100 == 0) begin
        drain();
        set_colors(COLOR_W'($urandom), COLOR_W'($urandom));
      end
      send_random(55, 25, 15);
    end
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_FG;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_func        = FUNC_WRITE;
    in_char_code   = '0;
    in_cell_row    = '0;
    in_cell_column = '0;
    fg_reg         = FG_RESET;
    bg_reg         = BG_RESET;
    blank_screen();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_color_registers();
    test_text_stream();
    test_backpressure();
    test_mixed_random();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
